### src/gwm_pkg.sv
`default_nettype none

package gwm_pkg;

  localparam int unsigned ChW = 8;
  localparam int unsigned OpW = 2;

  localparam logic [ChW-1:0] StarByte     = 8'd42;
  localparam logic [ChW-1:0] QuestionByte = 8'd63;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_VALUE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_END    = 2'd3
  } op_e;

endpackage

`default_nettype wire

### src/gwm_live_update.sv
`default_nettype none

// Star closure and one-byte advance of the live position vector.
// Closure fills each run of stars above a live star position, plus the
// position just past the run; that is a carry chain, so one add does it.
module gwm_live_update #(
  parameter int unsigned NUM_POS = 32
) (
  input  wire logic [NUM_POS:0]   live_i,   // live positions, not closed
  input  wire logic [NUM_POS-1:0] star_i,   // written position holds '*'
  input  wire logic [NUM_POS-1:0] hit_i,    // written non-star position matches byte
  output logic      [NUM_POS:0]   closed_o,
  output logic      [NUM_POS:0]   next_o
);

  logic [NUM_POS:0] star_ext;
  logic [NUM_POS:0] seed;
  logic [NUM_POS:0] fill_sum;

  assign star_ext = {1'b0, star_i};
  assign seed     = live_i & star_ext;
  assign fill_sum = seed + star_ext;
  assign closed_o = live_i | (fill_sum ^ star_ext);

  // a star stays on its own position, a hit moves one position up
  assign next_o = {1'b0, closed_o[NUM_POS-1:0] & star_i}
                | {closed_o[NUM_POS-1:0] & hit_i, 1'b0};

endmodule

`default_nettype wire

### src/glob_wildcard_matcher.sv
`default_nettype none

// Glob matcher for '*' (any run of bytes, empty too) and '?' (any one byte).
// Each input word carries an op in tuser: append a pattern byte, feed a value
// byte, clear the pattern, or end the value. Only an end-of-value word
// produces an output word: bit 0 matched, bit 1 set if pattern bytes were
// dropped since the last clear because MAX_PATTERN bytes were already held.
// One word is taken per cycle while no end-of-value word stalls. A word is
// held in the input register, and an end-of-value result is registered in
// the output register as its word leaves the input register. An end-of-value
// word stalls in the input register, and so stalls the input, only while the
// previous result is still unread. The update of all pattern positions is
// parallel, and runs of stars are resolved by one MAX_PATTERN+1 bit add, so
// the pattern length does not change the rate. Appending pattern bytes during
// a value is allowed; the new position takes part from the next value byte on.
module glob_wildcard_matcher
  import gwm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [7:0]       s_axis_tdata_i,   // [7:0] ch
  input  wire logic [OpW-1:0]   s_axis_tuser_i,   // [1:0] op
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o    // [0] matched, [1] pattern_overflow, rest 0
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // input register
  logic           in_valid_q;
  op_e            in_op_q;
  logic [ChW-1:0] in_ch_q;

  // pattern state
  logic [ChW-1:0]       pat_q [MAX_PATTERN];
  logic [LenW-1:0]      len_q, len_d;
  logic                 ovf_q, ovf_d;
  logic [MAX_PATTERN:0] live_q, live_d;

  // output register
  logic out_valid_q, out_valid_d;
  logic out_match_q, out_ovf_q;

  logic proceed;
  logic store_full;
  logic do_write;

  logic [MAX_PATTERN-1:0] written;
  logic [MAX_PATTERN-1:0] star_mask;
  logic [MAX_PATTERN-1:0] hit_mask;
  logic [MAX_PATTERN:0]   closed;
  logic [MAX_PATTERN:0]   next_live;

  assign proceed = in_valid_q
                 && ((in_op_q != OP_END) || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || proceed;
  assign store_full = (len_q == LenW'(MAX_PATTERN));
  assign do_write   = proceed && (in_op_q == OP_APPEND) && !store_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_op_q <= op_e'(s_axis_tuser_i);
      in_ch_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      pat_q[len_q[IdxW-1:0]] <= in_ch_q;
    end
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pos
    assign written[i]   = (LenW'(i) < len_q);
    assign star_mask[i] = written[i] && (pat_q[i] == StarByte);
    assign hit_mask[i]  = written[i] && (pat_q[i] != StarByte)
                        && ((pat_q[i] == QuestionByte) || (pat_q[i] == in_ch_q));
  end

  gwm_live_update #(
    .NUM_POS (MAX_PATTERN)
  ) u_live_update (
    .live_i   (live_q),
    .star_i   (star_mask),
    .hit_i    (hit_mask),
    .closed_o (closed),
    .next_o   (next_live)
  );

  always_comb begin
    len_d  = len_q;
    ovf_d  = ovf_q;
    live_d = live_q;
    if (proceed) begin
      unique case (in_op_q)
        OP_APPEND: begin
          if (store_full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + LenW'(1);
          end
        end
        OP_VALUE: begin
          live_d = next_live;
        end
        OP_CLEAR: begin
          len_d  = '0;
          ovf_d  = 1'b0;
          live_d = (MAX_PATTERN + 1)'(1);
        end
        OP_END: begin
          live_d = (MAX_PATTERN + 1)'(1);
        end
        default: begin
          live_d = live_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (proceed && (in_op_q == OP_END)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      live_q      <= (MAX_PATTERN + 1)'(1);
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed && (in_op_q == OP_END)) begin
      out_match_q <= closed[len_q];
      out_ovf_q   <= ovf_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_ovf_q, out_match_q};

  // overflow is only ever raised with a full store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> store_full)
    else $error("overflow flag set with store not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MAX_PATTERN))
    else $error("pattern length beyond store size");

  // no live position past the end of the pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_q & ~{written, 1'b1}) == '0)
    else $error("live position beyond pattern length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && (in_op_q == OP_END)) |=> (live_q == (MAX_PATTERN + 1)'(1)))
    else $error("live vector not restarted after end of value");

  // an end-of-value word never overwrites a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !(proceed && (in_op_q == OP_END)))
    else $error("result overwritten under backpressure");

endmodule

`default_nettype wire
